### rtl/assert_macros.svh
// Assertion macros used by the checker module of this block.
// Every assertion samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is ignored while rst is high.
`define VRTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that is also checked during reset.
`define VRTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/vrta_pkg.sv
`default_nettype none
package vrta_pkg;

  // Request types.
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_CHECK   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MEMORY = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Configuration register indexes.
  localparam logic REG_POOL_BASE  = 1'b0;
  localparam logic REG_POOL_BYTES = 1'b1;

  localparam int PAGES_W = 21;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic init;   // load entry 0 with the bookkeeping page
    logic alloc;  // load the entry whose index equals the region count
    logic step;   // advance the search wave by one cell
    logic shift;  // close the gap left by the released entry
  } vrta_cmd_t;

  // What one cell hands to the cell below it.
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic        match;
    logic        hit;
    logic [31:0] hsize;
    logic [31:0] bbase;
    logic [31:0] bsize;
    logic        blast;
  } vrta_link_t;

endpackage
`default_nettype wire

### rtl/vrta_cell.sv
`default_nettype none
module vrta_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 9
) (
  input  logic                clk,
  input  vrta_pkg::vrta_cmd_t  cmd,
  input  logic [31:0]         wr_base,
  input  logic [31:0]         wr_size,
  input  logic [31:0]         cmp_addr,
  input  logic [CNT_W-1:0]    count,
  input  vrta_pkg::vrta_link_t up,
  output vrta_pkg::vrta_link_t down
);
  import vrta_pkg::*;

  logic [31:0] base;
  logic [31:0] size;
  logic        hit;
  logic [31:0] hsize;
  logic [31:0] bbase;
  logic [31:0] bsize;
  logic        blast;
  logic        match;
  logic        is_below_last;

  // Only live entries above the bookkeeping page take part in a search.
  assign match = (base == cmp_addr) && (INDEX > 0) && (CNT_W'(INDEX) < count);

  // True when the entry above this one is the last live entry or lies past it.
  assign is_below_last = ((CNT_W + 1)'(INDEX + 2) >= {1'b0, count});

  always_ff @(posedge clk) begin
    if (cmd.init && (INDEX == 0)) begin
      base <= wr_base;
      size <= wr_size;
    end else if (cmd.alloc && (count == CNT_W'(INDEX))) begin
      base <= wr_base;
      size <= wr_size;
    end else if (cmd.shift && !hit) begin
      base <= up.base;
      size <= up.size;
    end
  end

  // The wave keeps the highest match seen so far, plus the entry just below it.
  // A table restart clears the hit flags so the first search starts clean.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      hit <= 1'b0;
    end else if (cmd.step) begin
      hit <= up.hit | up.match;
      if (up.hit) begin
        hsize <= up.hsize;
        bbase <= up.bbase;
        bsize <= up.bsize;
        blast <= up.blast;
      end else begin
        hsize <= up.size;
        bbase <= base;
        bsize <= size;
        blast <= is_below_last;
      end
    end
  end

  assign down = '{base: base, size: size, match: match, hit: hit, hsize: hsize,
                  bbase: bbase, bsize: bsize, blast: blast};

endmodule
`default_nettype wire

### rtl/virtual_region_table_allocator_core.sv
`default_nettype none
// Bump allocator over a virtual address pool with a table of regions. The table is a
// row of MAX_REGIONS cells, one entry each; entry 0 is the bookkeeping page at the
// pool base. An allocate or check request is accepted in the idle state, then executed
// in the execute state, which writes the result word. A release is accepted, then a
// search wave walks from the top cell down to cell 0 one cell per clock
// (MAX_REGIONS - 1 steps) and carries the highest matching entry with it, then the
// finish state shifts all later entries down by one. One request is in flight at a
// time; a new request word is taken as soon as the previous one has been executed,
// even while its result word is still waiting on a stalled output. Writing either
// configuration register restarts the table with only the bookkeeping page; a
// configuration word that is offered holds off new request words, so a write only
// lands while nothing is in flight. There is no clearing pass after reset.
// PAGE_BYTES must be a power of two.
module virtual_region_table_allocator_core #(
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_REGIONS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] req_size,
  input  logic [31:0] req_address,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] region_address,
  output logic [20:0] region_pages,
  output logic        in_pool,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import vrta_pkg::*;

  localparam int CNT_W    = $clog2(MAX_REGIONS + 1);
  localparam int SCNT_W   = $clog2(MAX_REGIONS);
  localparam int PAGE_LOG = $clog2(PAGE_BYTES);
  localparam logic [31:0] PAGE32   = 32'(PAGE_BYTES);
  localparam logic [32:0] PAGE_M1  = 33'(PAGE_BYTES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]        state;
  logic [SCNT_W-1:0] steps;
  logic [1:0]        rq_type;
  logic [31:0]       rq_size;
  logic [31:0]       rq_addr;
  logic [31:0]       pool_base;
  logic [31:0]       pool_bytes;
  logic [CNT_W-1:0]  count;
  logic [31:0]       free_bytes;
  // End of the last live entry; the next allocation starts here.
  logic [31:0]       tail;

  logic        in_take;
  logic        cfg_we;
  logic        out_free;
  logic [31:0] new_base;
  logic [31:0] new_bytes;

  logic [32:0] round_sum;
  logic [32:0] alloc_bytes;
  logic [32:0] alloc_pages;
  logic        table_full;
  logic        no_mem;
  logic [32:0] pool_hi;
  logic        addr_in;
  logic [32:0] rel_sum;
  logic [31:0] rel_pages;

  vrta_cmd_t   cmd;
  logic [31:0] wr_base;
  logic [31:0] wr_size;
  vrta_link_t  link [MAX_REGIONS+1];

  // A pending configuration word goes ahead of any request word.
  assign in_stall  = rst | (state != S_IDLE) | cfg_valid;
  assign cfg_ready = !rst && (state == S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;

  // Register values after a configuration write, used to rebuild entry 0.
  always_comb begin
    new_base  = pool_base;
    new_bytes = pool_bytes;
    if (rst) begin
      new_base  = '0;
      new_bytes = '0;
    end else if (cfg_index == REG_POOL_BASE) begin
      new_base = cfg_data;
    end else begin
      new_bytes = cfg_data;
    end
  end

  // Allocation: round up to whole pages, then test against the free count.
  assign round_sum   = {1'b0, rq_size} + PAGE_M1;
  assign alloc_bytes = round_sum & ~PAGE_M1;
  assign alloc_pages = round_sum >> PAGE_LOG;
  assign table_full  = (count >= CNT_W'(MAX_REGIONS));
  assign no_mem      = alloc_bytes > {1'b0, free_bytes};

  // Address check against the inclusive pool bounds, upper bound in 33 bits.
  assign pool_hi = {1'b0, pool_base} + {1'b0, pool_bytes};
  assign addr_in = (rq_addr >= pool_base) && ({1'b0, rq_addr} <= pool_hi);

  // Release: the wave result arrives at cell 0.
  assign rel_sum   = {1'b0, free_bytes} + {1'b0, link[0].hsize};
  assign rel_pages = link[0].hsize >> PAGE_LOG;

  always_comb begin
    cmd.init  = rst | cfg_we;
    cmd.alloc = (state == S_EXEC) && out_free && (rq_type == REQ_ALLOC) &&
                !table_full && !no_mem;
    cmd.step  = (state == S_SEARCH);
    cmd.shift = (state == S_FINISH) && out_free && link[0].hit;
    if (cmd.init) begin
      wr_base = new_base;
      wr_size = PAGE32;
    end else begin
      wr_base = tail;
      wr_size = alloc_bytes[31:0];
    end
  end

  // The row of table cells; each hands its contents to the cell below.
  assign link[MAX_REGIONS] = '0;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    vrta_cell #(
      .INDEX(i),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .wr_base (wr_base),
      .wr_size (wr_size),
      .cmp_addr(rq_addr),
      .count   (count),
      .up      (link[i+1]),
      .down    (link[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pool_base  <= '0;
      pool_bytes <= '0;
      count      <= CNT_W'(1);
      free_bytes <= '0;
      tail       <= PAGE32;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        pool_base  <= new_base;
        pool_bytes <= new_bytes;
        count      <= CNT_W'(1);
        free_bytes <= (new_bytes >= PAGE32) ? (new_bytes - PAGE32) : '0;
        tail       <= new_base + PAGE32;
      end

      case (state)
        S_IDLE: begin
          if (in_take) begin
            rq_type <= req_type;
            rq_size <= req_size;
            rq_addr <= req_address;
            steps   <= SCNT_W'(MAX_REGIONS - 1);
            state   <= (req_type == REQ_RELEASE) ? S_SEARCH : S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= ST_OK;
            region_address <= '0;
            region_pages   <= '0;
            in_pool        <= 1'b0;
            if (rq_type == REQ_ALLOC) begin
              if (table_full) begin
                status <= ST_TABLE_FULL;
              end else if (no_mem) begin
                status <= ST_NO_MEMORY;
              end else begin
                region_address <= tail;
                region_pages   <= alloc_pages[PAGES_W-1:0];
                count          <= count + CNT_W'(1);
                free_bytes     <= free_bytes - alloc_bytes[31:0];
                tail           <= tail + alloc_bytes[31:0];
              end
            end else if (rq_type == REQ_CHECK) begin
              in_pool <= addr_in;
            end
            state <= S_IDLE;
          end
        end
        S_SEARCH: begin
          steps <= steps - SCNT_W'(1);
          if (steps == SCNT_W'(1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            in_pool   <= 1'b0;
            if (link[0].hit) begin
              status         <= ST_OK;
              region_address <= rq_addr;
              region_pages   <= rel_pages[PAGES_W-1:0];
              count          <= count - CNT_W'(1);
              free_bytes     <= rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0];
              // Removing the last entry moves the tail back to the entry below it.
              if (link[0].blast) begin
                tail <= link[0].bbase + link[0].bsize;
              end
            end else begin
              status         <= ST_NOT_FOUND;
              region_address <= '0;
              region_pages   <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/vrta_checker.sv
`default_nettype none
`include "assert_macros.svh"
module vrta_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [31:0] region_address,
  input wire logic [20:0] region_pages,
  input wire logic        in_pool
);
  import vrta_pkg::*;

  `VRTA_ASSERT_ALWAYS(a_out_idle_after_reset, rst |=> !out_valid, "result word after reset")
  `VRTA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result word dropped")
  `VRTA_ASSERT(a_fail_fields_zero, out_valid && status != ST_OK |-> region_address == 32'd0 && region_pages == 21'd0 && !in_pool, "failed request has nonzero fields")
  `VRTA_ASSERT(a_one_in_flight, in_valid && !in_stall |=> in_stall, "second request taken while one is in flight")

endmodule

bind virtual_region_table_allocator_core vrta_checker u_vrta_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .region_address(region_address),
  .region_pages  (region_pages),
  .in_pool       (in_pool)
);
`default_nettype wire
